@@ sv/hrlp_pkg.sv @@
// Shared types and constants for the HTTP request line parser.
package hrlp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_TARGET = 3'd1,
        PH_EXTRA  = 3'd2,
        PH_CR     = 3'd3,
        PH_END    = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    localparam logic [1:0] CODE_GET  = 2'd0;
    localparam logic [1:0] CODE_HEAD = 2'd1;
    localparam logic [1:0] CODE_POST = 2'd2;
    localparam logic [1:0] CODE_NONE = 2'd3;

    localparam int NAME_COUNT = 3;

    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Method names, one row per name, padded with NUL.
    localparam logic [7:0] NAME_CHARS [NAME_COUNT][4] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00},  // GET
        '{8'h48, 8'h45, 8'h41, 8'h44},  // HEAD
        '{8'h50, 8'h4F, 8'h53, 8'h54}   // POST
    };
    localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{3'd3, 3'd4, 3'd4};

    typedef struct packed {
        t_phase     phase;
        logic [1:0] method_code;
        logic       uri_byte_valid;
        logic [7:0] uri_byte;
        logic [7:0] uri_index;
        logic [7:0] uri_length;
    } t_result;

endpackage

@@ sv/hrlp_parse_core.sv @@
// Parser state registers and the per-byte next-state and result logic.
module hrlp_parse_core #(
    parameter int URI_LIMIT = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte_in,
    input  logic               i_first,
    output hrlp_pkg::t_result  o_result
);

    localparam int CNT_W = $clog2(URI_LIMIT + 1);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

    hrlp_pkg::t_phase r_phase, n_phase, b_phase;
    logic [2:0]       r_alive, n_alive, b_alive;
    logic [2:0]       r_pos, n_pos, b_pos;
    logic [1:0]       r_method, n_method, b_method;
    logic [CNT_W-1:0] r_count, n_count, b_count;
    logic             uri_valid;
    logic [CNT_W-1:0] uri_idx;
    logic [1:0]       code;
    logic [EXT_W-1:0] idx_ext;
    logic [EXT_W-1:0] len_ext;

    always_comb begin
        // Restart before this byte when first is set.
        b_phase  = i_first ? hrlp_pkg::PH_METHOD : r_phase;
        b_alive  = i_first ? 3'b111 : r_alive;
        b_pos    = i_first ? 3'd0 : r_pos;
        b_method = i_first ? hrlp_pkg::CODE_NONE : r_method;
        b_count  = i_first ? '0 : r_count;

        n_phase   = b_phase;
        n_alive   = b_alive;
        n_pos     = b_pos;
        n_method  = b_method;
        n_count   = b_count;
        uri_valid = 1'b0;
        uri_idx   = '0;
        code      = hrlp_pkg::CODE_NONE;

        case (b_phase)
            hrlp_pkg::PH_METHOD: begin
                if (i_byte_in == hrlp_pkg::CHAR_SP) begin
                    for (int k = 0; k < hrlp_pkg::NAME_COUNT; k++) begin
                        if (b_alive[k] && (hrlp_pkg::NAME_LEN[k] == b_pos)) begin
                            code = 2'(k);
                        end
                    end
                    n_method = code;
                    n_phase  = hrlp_pkg::PH_TARGET;
                end else begin
                    for (int k = 0; k < hrlp_pkg::NAME_COUNT; k++) begin
                        if (!((b_pos < hrlp_pkg::NAME_LEN[k]) &&
                              (hrlp_pkg::NAME_CHARS[k][b_pos[1:0]] == i_byte_in))) begin
                            n_alive[k] = 1'b0;
                        end
                    end
                    if (b_pos != 3'd7) begin
                        n_pos = b_pos + 3'd1;
                    end
                end
            end
            hrlp_pkg::PH_TARGET: begin
                if (i_byte_in == hrlp_pkg::CHAR_SP) begin
                    n_phase = hrlp_pkg::PH_EXTRA;
                end else if (b_count < CNT_W'(URI_LIMIT)) begin
                    uri_valid = 1'b1;
                    uri_idx   = b_count;
                    n_count   = b_count + CNT_W'(1);
                end else begin
                    n_phase = hrlp_pkg::PH_ERROR;
                end
            end
            hrlp_pkg::PH_EXTRA: begin
                if (i_byte_in == hrlp_pkg::CHAR_CR) begin
                    n_phase = hrlp_pkg::PH_CR;
                end
            end
            hrlp_pkg::PH_CR: begin
                n_phase = (i_byte_in == hrlp_pkg::CHAR_LF) ? hrlp_pkg::PH_END
                                                           : hrlp_pkg::PH_ERROR;
            end
            default: begin
                n_phase = hrlp_pkg::PH_ERROR;
            end
        endcase

        idx_ext = EXT_W'(uri_idx);
        len_ext = EXT_W'(n_count);

        o_result.phase          = n_phase;
        o_result.method_code    = (n_phase == hrlp_pkg::PH_METHOD) ? hrlp_pkg::CODE_NONE
                                                                   : n_method;
        o_result.uri_byte_valid = uri_valid;
        o_result.uri_byte       = uri_valid ? i_byte_in : 8'd0;
        o_result.uri_index      = idx_ext[7:0];
        o_result.uri_length     = len_ext[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrlp_pkg::PH_METHOD;
            r_alive  <= 3'b111;
            r_pos    <= 3'd0;
            r_method <= hrlp_pkg::CODE_NONE;
            r_count  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_alive  <= n_alive;
            r_pos    <= n_pos;
            r_method <= n_method;
            r_count  <= n_count;
        end
    end

endmodule

@@ sv/hrlp_out_stage.sv @@
// Result register with valid/stall handshake toward the consumer.
module hrlp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hrlp_pkg::t_result  i_result,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output hrlp_pkg::t_result  o_result
);

    logic              r_valid;
    hrlp_pkg::t_result r_result;

    // Free when empty or when the held beat leaves this cycle.
    assign o_free   = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ sv/http_request_line_parser_unit.sv @@
// Top level of the HTTP request line parser: one byte in, one result out.
//
// Feed one byte of a request line per input beat; raise i_first with the
// first byte of each line to restart parsing. Every accepted byte yields
// exactly one result beat carrying the phase after that byte (method,
// target, extra, after CR, end, error), the recognized method (GET, HEAD,
// POST, or not supported / still undecided), and, for target bytes, the
// byte itself with its index and the running target length. Up to URI_LIMIT
// target bytes are taken; one more gives error, which holds until i_first.
// Throughput is one byte per cycle while the consumer does not stall: the phase
// machine and the three-name compare settle between the parser state
// registers and a single result register. o_stall is high only while a
// result beat is held and the consumer stalls.
module http_request_line_parser_unit #(
    parameter int URI_LIMIT = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_first,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_phase,
    output logic [1:0] o_method_code,
    output logic       o_uri_byte_valid,
    output logic [7:0] o_uri_byte,
    output logic [7:0] o_uri_index,
    output logic [7:0] o_uri_length
);

    logic              out_free;
    logic              accept;
    hrlp_pkg::t_result next_result;
    hrlp_pkg::t_result held_result;

    // Accept a byte whenever the result register can take its beat.
    assign o_stall = !out_free;
    assign accept  = i_valid && out_free;

    hrlp_parse_core #(
        .URI_LIMIT (URI_LIMIT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte_in (i_byte_in),
        .i_first   (i_first),
        .o_result  (next_result)
    );

    hrlp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (next_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (held_result)
    );

    // Unpack the held result onto the field ports.
    assign o_phase          = held_result.phase;
    assign o_method_code    = held_result.method_code;
    assign o_uri_byte_valid = held_result.uri_byte_valid;
    assign o_uri_byte       = held_result.uri_byte;
    assign o_uri_index      = held_result.uri_index;
    assign o_uri_length     = held_result.uri_length;

    // Stall upstream only while a beat is held.
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with empty result register");

    // A target byte beat carries the target phase.
    a_uri_in_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_uri_byte_valid) |-> (o_phase == hrlp_pkg::PH_TARGET))
        else $error("target byte outside target phase");

    // Length runs one ahead of the index of the byte just taken.
    a_len_follows_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_uri_byte_valid) |-> (o_uri_length == 8'(o_uri_index + 8'd1)))
        else $error("target length does not follow index");

    // No method is reported while still in method phase.
    a_method_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_phase == hrlp_pkg::PH_METHOD)) |->
            (o_method_code == hrlp_pkg::CODE_NONE))
        else $error("method reported during method phase");

    // Non-target beats carry zero byte and index.
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_uri_byte_valid) |-> ((o_uri_byte == 8'd0) && (o_uri_index == 8'd0)))
        else $error("target fields set on non-target beat");

endmodule
